@@ hw/rtl/bicubic_power_surface_eval_assert.svh @@
`ifndef BICUBIC_POWER_SURFACE_EVAL_ASSERT_SVH
`define BICUBIC_POWER_SURFACE_EVAL_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define BPSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent must hold later, after the delay given by dly
`define BPSE_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bpse_pkg.sv @@
package bpse_pkg;

    localparam int MAX_SEGMENTS_DEF = 8;
    localparam int COMPONENTS_DEF   = 4;
    localparam int COEF_COUNT       = 16;
    localparam int ROW_COUNT        = 4;
    localparam int Q_W              = 32;
    localparam int FRAC             = 16;
    localparam int CNT_W            = 4;
    localparam int IDX_W            = 4;
    localparam int COMP_W           = 2;
    localparam int SPAN_OUT_W       = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int S_STEPS          = 3;
    localparam int HORNER_STEPS     = 6;
    // accept edge to strobe: input, span, offset, two stages per horner step
    localparam int PIPE_LAT         = 3 + 2 * HORNER_STEPS;

    localparam logic [CFG_IDX_W-1:0] CFG_U_SEGS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_V_SEGS = CFG_IDX_W'(1);

    localparam logic signed [2*Q_W-1:0] ROUND_HALF = 64'sd32768;

    typedef enum logic [1:0] {
        ACT_U_KNOT = 2'd0,
        ACT_V_KNOT = 2'd1,
        ACT_COEF   = 2'd2,
        ACT_EVAL   = 2'd3
    } t_action;

    typedef logic signed [Q_W-1:0] t_q;

    // {overflow, value} of a 33-bit sum clipped to 32 bits
    function automatic logic [Q_W:0] sat_q(input logic [Q_W:0] x);
        logic [Q_W:0] res;
        if (x[Q_W] != x[Q_W-1]) begin
            res = {1'b1, x[Q_W], {(Q_W-1){~x[Q_W]}}};
        end else begin
            res = {1'b0, x[Q_W-1:0]};
        end
        return res;
    endfunction

    // round half up, clip, add coefficient, clip again
    function automatic logic [Q_W:0] qmac_tail(input logic signed [2*Q_W-1:0] prod,
                                               input t_q c);
        logic signed [2*Q_W-1:0] rp;
        logic [2*Q_W-FRAC-1:0]   sh;
        logic                    mo;
        t_q                      m;
        logic [Q_W:0]            r;
        rp = prod + ROUND_HALF;
        sh = rp[2*Q_W-1:FRAC];
        mo = !((&sh[2*Q_W-FRAC-1:Q_W-1]) || (~|sh[2*Q_W-FRAC-1:Q_W-1]));
        if (mo) begin
            m = {sh[2*Q_W-FRAC-1], {(Q_W-1){~sh[2*Q_W-FRAC-1]}}};
        end else begin
            m = sh[Q_W-1:0];
        end
        r = sat_q({m[Q_W-1], m} + {c[Q_W-1], c});
        return {mo | r[Q_W], r[Q_W-1:0]};
    endfunction

endpackage

@@ hw/rtl/bpse_ram.sv @@
module bpse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bicubic_power_surface_eval.sv @@
// Bicubic power-basis surface evaluator, signed Q16.16, saturating. One transaction is
// taken in every cycle and busy never rises; knot and coefficient loads flow through the
// same pipe as evaluations, so they take effect in order. An evaluation passes through
// the input register, span search, offset and coefficient read, then six horner steps
// of a multiply stage and a round/add stage each, before its result shows on o_valid;
// the result strobe lasts one cycle and cannot be held off by the receiver.
// Loads give no result. Knots and coefficients read before they are written are
// undefined; coefficients live in 16 x components banks of one entry per patch.
module bicubic_power_surface_eval #(
    parameter int MAX_SEGMENTS = bpse_pkg::MAX_SEGMENTS_DEF,
    parameter int COMPONENTS   = bpse_pkg::COMPONENTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [1:0]                       i_action,
    input  logic [bpse_pkg::IDX_W-1:0]       i_u_index,
    input  logic [bpse_pkg::IDX_W-1:0]       i_v_index,
    input  logic [bpse_pkg::IDX_W-1:0]       i_coef_index,
    input  logic [bpse_pkg::COMP_W-1:0]      i_component,
    input  logic signed [bpse_pkg::Q_W-1:0]  i_write_value,
    input  logic signed [bpse_pkg::Q_W-1:0]  i_u_param,
    input  logic signed [bpse_pkg::Q_W-1:0]  i_v_param,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bpse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpse_pkg::CNT_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    output logic signed [bpse_pkg::Q_W-1:0]  o_x_value,
    output logic signed [bpse_pkg::Q_W-1:0]  o_y_value,
    output logic signed [bpse_pkg::Q_W-1:0]  o_z_value,
    output logic signed [bpse_pkg::Q_W-1:0]  o_w_value,
    output logic [bpse_pkg::SPAN_OUT_W-1:0]  o_u_span,
    output logic [bpse_pkg::SPAN_OUT_W-1:0]  o_v_span,
    output logic                             o_overflow
);

    import bpse_pkg::*;

    localparam int SPAN_W     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int ADDR_W     = 2 * SPAN_W;
    localparam int BANK_DEPTH = 1 << ADDR_W;

    typedef t_q t_knots [0:MAX_SEGMENTS];

    typedef struct packed {
        logic              valid;
        logic [SPAN_W-1:0] j;
        logic [SPAN_W-1:0] k;
        t_q                s;
        t_q                t;
        logic              ovf;
    } t_side;

    function automatic logic [CNT_W-1:0] seg_count(input logic [CNT_W-1:0] r);
        logic [CNT_W-1:0] c;
        if (r == '0) begin
            c = CNT_W'(1);
        end else if (int'(r) > MAX_SEGMENTS) begin
            c = CNT_W'(MAX_SEGMENTS);
        end else begin
            c = r;
        end
        return c;
    endfunction

    // highest index in 0..cnt whose knot is at or below p, then clamped to cnt - 1
    function automatic logic [CNT_W-1:0] find_span(input t_knots kn,
                                                   input logic [CNT_W-1:0] cnt,
                                                   input t_q p);
        logic [CNT_W-1:0] sp;
        sp = '0;
        for (int i = 0; i <= MAX_SEGMENTS; i++) begin
            if (i <= int'(cnt) && kn[i] <= p) begin
                sp = CNT_W'(i);
            end
        end
        if (sp >= cnt) begin
            sp = cnt - 1'b1;
        end
        return sp;
    endfunction

    function automatic t_q pick_knot(input t_knots kn, input logic [CNT_W-1:0] sp);
        t_q kv;
        kv = '0;
        for (int i = 0; i <= MAX_SEGMENTS; i++) begin
            if (i == int'(sp)) begin
                kv = kn[i];
            end
        end
        return kv;
    endfunction

    // configuration
    logic [CNT_W-1:0] r_u_seg;
    logic [CNT_W-1:0] r_v_seg;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_seg <= CNT_W'(1);
            r_v_seg <= CNT_W'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_U_SEGS) begin
                r_u_seg <= i_cfg_data;
            end
            if (i_cfg_index == CFG_V_SEGS) begin
                r_v_seg <= i_cfg_data;
            end
        end
    end

    // stage 1: input register
    logic               r_s1_go;
    t_action            r_s1_act;
    logic [IDX_W-1:0]   r_s1_ui;
    logic [IDX_W-1:0]   r_s1_vi;
    logic [IDX_W-1:0]   r_s1_ci;
    logic [COMP_W-1:0]  r_s1_comp;
    t_q                 r_s1_wv;
    t_q                 r_s1_up;
    t_q                 r_s1_vp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_go <= 1'b0;
        end else begin
            r_s1_go <= i_start;
        end
        r_s1_act  <= t_action'(i_action);
        r_s1_ui   <= i_u_index;
        r_s1_vi   <= i_v_index;
        r_s1_ci   <= i_coef_index;
        r_s1_comp <= i_component;
        r_s1_wv   <= i_write_value;
        r_s1_up   <= i_u_param;
        r_s1_vp   <= i_v_param;
    end

    // knot stores: written and searched in stage 1, so accesses stay in order
    t_knots r_u_knot;
    t_knots r_v_knot;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= MAX_SEGMENTS; i++) begin
            if (r_s1_go && r_s1_act == ACT_U_KNOT && int'(r_s1_ui) == i) begin
                r_u_knot[i] <= r_s1_wv;
            end
            if (r_s1_go && r_s1_act == ACT_V_KNOT && int'(r_s1_vi) == i) begin
                r_v_knot[i] <= r_s1_wv;
            end
        end
    end

    logic [CNT_W-1:0] u_sp;
    logic [CNT_W-1:0] v_sp;
    logic             coef_ok;

    always_comb begin
        u_sp    = find_span(r_u_knot, seg_count(r_u_seg), r_s1_up);
        v_sp    = find_span(r_v_knot, seg_count(r_v_seg), r_s1_vp);
        coef_ok = (int'(r_s1_ui) < MAX_SEGMENTS) && (int'(r_s1_vi) < MAX_SEGMENTS)
                  && (int'(r_s1_comp) < COMPONENTS);
    end

    // stage 2: span, knot values, coefficient write request
    logic               r_s2_eval;
    logic               r_s2_cwe;
    logic [SPAN_W-1:0]  r_s2_j;
    logic [SPAN_W-1:0]  r_s2_k;
    t_q                 r_s2_up;
    t_q                 r_s2_vp;
    t_q                 r_s2_ku;
    t_q                 r_s2_kv;
    logic [IDX_W-1:0]   r_s2_ci;
    logic [COMP_W-1:0]  r_s2_comp;
    t_q                 r_s2_wv;
    logic [ADDR_W-1:0]  r_s2_waddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_eval <= 1'b0;
            r_s2_cwe  <= 1'b0;
        end else begin
            r_s2_eval <= r_s1_go && r_s1_act == ACT_EVAL;
            r_s2_cwe  <= r_s1_go && r_s1_act == ACT_COEF && coef_ok;
        end
        r_s2_j     <= SPAN_W'(u_sp);
        r_s2_k     <= SPAN_W'(v_sp);
        r_s2_up    <= r_s1_up;
        r_s2_vp    <= r_s1_vp;
        r_s2_ku    <= pick_knot(r_u_knot, u_sp);
        r_s2_kv    <= pick_knot(r_v_knot, v_sp);
        r_s2_ci    <= r_s1_ci;
        r_s2_comp  <= r_s1_comp;
        r_s2_wv    <= r_s1_wv;
        r_s2_waddr <= {SPAN_W'(r_s1_ui), SPAN_W'(r_s1_vi)};
    end

    // coefficient banks, one per coefficient and component, addressed by patch
    logic [Q_W-1:0] rd [0:COMPONENTS-1][0:COEF_COUNT-1];

    for (genvar c = 0; c < COMPONENTS; c++) begin : g_comp
        for (genvar ci = 0; ci < COEF_COUNT; ci++) begin : g_coef
            bpse_ram #(
                .WIDTH (Q_W),
                .DEPTH (BANK_DEPTH)
            ) u_bank (
                .i_clk   (i_clk),
                .i_we    (r_s2_cwe && r_s2_comp == COMP_W'(c) && r_s2_ci == IDX_W'(ci)),
                .i_waddr (r_s2_waddr),
                .i_wdata (r_s2_wv),
                .i_raddr ({r_s2_j, r_s2_k}),
                .o_rdata (rd[c][ci])
            );
        end
    end

    // stage 3: local offsets
    logic [Q_W:0] s_sat;
    logic [Q_W:0] t_sat;
    t_side        r_s3;

    always_comb begin
        s_sat = sat_q({r_s2_up[Q_W-1], r_s2_up} - {r_s2_ku[Q_W-1], r_s2_ku});
        t_sat = sat_q({r_s2_vp[Q_W-1], r_s2_vp} - {r_s2_kv[Q_W-1], r_s2_kv});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else begin
            r_s3.valid <= r_s2_eval;
        end
        r_s3.j     <= r_s2_j;
        r_s3.k     <= r_s2_k;
        r_s3.s     <= s_sat[Q_W-1:0];
        r_s3.t     <= t_sat[Q_W-1:0];
        r_s3.ovf   <= s_sat[Q_W] | t_sat[Q_W];
    end

    // horner pipeline: rows in s first, then the row results in t (kept in row 3)
    t_q    lv_acc  [0:HORNER_STEPS][0:COMPONENTS-1][0:ROW_COUNT-1];
    t_q    lv_cf   [0:S_STEPS-1][0:COMPONENTS-1][0:COEF_COUNT-1];
    t_side lv_side [0:HORNER_STEPS];

    assign lv_side[0] = r_s3;

    for (genvar c = 0; c < COMPONENTS; c++) begin : g_lv0
        for (genvar r = 0; r < ROW_COUNT; r++) begin : g_row
            assign lv_acc[0][c][r] = rd[c][ROW_COUNT*r+3];
        end
        for (genvar ci = 0; ci < COEF_COUNT; ci++) begin : g_cf
            assign lv_cf[0][c][ci] = rd[c][ci];
        end
    end

    for (genvar n = 0; n < HORNER_STEPS; n++) begin : g_step
        t_side                   r_m_side;
        t_side                   r_a_side;
        t_side                   n_a_side;
        logic signed [2*Q_W-1:0] r_prod [0:COMPONENTS-1][0:ROW_COUNT-1];
        t_q                      r_m_acc [0:COMPONENTS-1][0:ROW_COUNT-1];
        t_q                      r_a_acc [0:COMPONENTS-1][0:ROW_COUNT-1];
        t_q                      n_acc   [0:COMPONENTS-1][0:ROW_COUNT-1];
        logic                    n_ovf;
        t_q                      x_mul;

        assign x_mul = (n < S_STEPS) ? lv_side[n].s : lv_side[n].t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_side <= '0;
            end else begin
                r_m_side <= lv_side[n];
            end
            for (int c = 0; c < COMPONENTS; c++) begin
                for (int r = 0; r < ROW_COUNT; r++) begin
                    r_prod[c][r]  <= lv_acc[n][c][r] * x_mul;
                    r_m_acc[c][r] <= lv_acc[n][c][r];
                end
            end
        end

        if (n < S_STEPS) begin : g_s
            t_q r_m_cf [0:COMPONENTS-1][0:COEF_COUNT-1];

            always_ff @(posedge i_clk) begin
                r_m_cf <= lv_cf[n];
            end

            always_comb begin
                logic [Q_W:0] tl;
                n_ovf = 1'b0;
                for (int c = 0; c < COMPONENTS; c++) begin
                    for (int r = 0; r < ROW_COUNT; r++) begin
                        tl           = qmac_tail(r_prod[c][r], r_m_cf[c][ROW_COUNT*r+2-n]);
                        n_acc[c][r]  = tl[Q_W-1:0];
                        n_ovf        = n_ovf | tl[Q_W];
                    end
                end
            end

            if (n < S_STEPS - 1) begin : g_carry
                t_q r_a_cf [0:COMPONENTS-1][0:COEF_COUNT-1];

                always_ff @(posedge i_clk) begin
                    r_a_cf <= r_m_cf;
                end

                assign lv_cf[n+1] = r_a_cf;
            end
        end else begin : g_t
            always_comb begin
                logic [Q_W:0] tl;
                n_ovf = 1'b0;
                for (int c = 0; c < COMPONENTS; c++) begin
                    for (int r = 0; r < ROW_COUNT; r++) begin
                        n_acc[c][r] = r_m_acc[c][r];
                    end
                    tl          = qmac_tail(r_prod[c][ROW_COUNT-1],
                                            r_m_acc[c][2-(n-S_STEPS)]);
                    n_acc[c][ROW_COUNT-1] = tl[Q_W-1:0];
                    n_ovf       = n_ovf | tl[Q_W];
                end
            end
        end

        always_comb begin
            n_a_side     = r_m_side;
            n_a_side.ovf = r_m_side.ovf | n_ovf;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_side <= '0;
            end else begin
                r_a_side <= n_a_side;
            end
            r_a_acc <= n_acc;
        end

        assign lv_side[n+1] = r_a_side;
        assign lv_acc[n+1]  = r_a_acc;
    end

    // result
    assign o_valid    = lv_side[HORNER_STEPS].valid;
    assign o_u_span   = SPAN_OUT_W'(lv_side[HORNER_STEPS].j);
    assign o_v_span   = SPAN_OUT_W'(lv_side[HORNER_STEPS].k);
    assign o_overflow = lv_side[HORNER_STEPS].ovf;
    assign o_x_value  = lv_acc[HORNER_STEPS][0][ROW_COUNT-1];
    assign o_y_value  = lv_acc[HORNER_STEPS][1][ROW_COUNT-1];
    assign o_z_value  = lv_acc[HORNER_STEPS][2][ROW_COUNT-1];

    if (COMPONENTS > 3) begin : g_w
        assign o_w_value = lv_acc[HORNER_STEPS][3][ROW_COUNT-1];
    end else begin : g_no_w
        assign o_w_value = '0;
    end

endmodule

@@ hw/rtl/bpse_chk.sv @@
`include "bicubic_power_surface_eval_assert.svh"

module bpse_chk #(
    parameter int MAX_SEGMENTS = bpse_pkg::MAX_SEGMENTS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_start,
    input logic                             o_busy,
    input logic [1:0]                       i_action,
    input logic [bpse_pkg::IDX_W-1:0]       i_u_index,
    input logic [bpse_pkg::IDX_W-1:0]       i_v_index,
    input logic [bpse_pkg::IDX_W-1:0]       i_coef_index,
    input logic [bpse_pkg::COMP_W-1:0]      i_component,
    input logic signed [bpse_pkg::Q_W-1:0]  i_write_value,
    input logic signed [bpse_pkg::Q_W-1:0]  i_u_param,
    input logic signed [bpse_pkg::Q_W-1:0]  i_v_param,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [bpse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [bpse_pkg::CNT_W-1:0]       i_cfg_data,
    input logic                             o_valid,
    input logic signed [bpse_pkg::Q_W-1:0]  o_x_value,
    input logic signed [bpse_pkg::Q_W-1:0]  o_y_value,
    input logic signed [bpse_pkg::Q_W-1:0]  o_z_value,
    input logic signed [bpse_pkg::Q_W-1:0]  o_w_value,
    input logic [bpse_pkg::SPAN_OUT_W-1:0]  o_u_span,
    input logic [bpse_pkg::SPAN_OUT_W-1:0]  o_v_span,
    input logic                             o_overflow
);

    import bpse_pkg::*;

    logic             eval_acc;
    logic [CNT_W-1:0] r_u_seg;
    logic [CNT_W-1:0] r_v_seg;
    logic [CNT_W-1:0] u_cnt;
    logic [CNT_W-1:0] v_cnt;
    logic             span_ok;

    assign eval_acc = i_start && !o_busy && i_action == ACT_EVAL;

    // shadow of the segment count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_seg <= CNT_W'(1);
            r_v_seg <= CNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_U_SEGS) begin
                r_u_seg <= i_cfg_data;
            end
            if (i_cfg_index == CFG_V_SEGS) begin
                r_v_seg <= i_cfg_data;
            end
        end
    end

    always_comb begin
        u_cnt = (r_u_seg == '0) ? CNT_W'(1) : r_u_seg;
        v_cnt = (r_v_seg == '0) ? CNT_W'(1) : r_v_seg;
        if (int'(u_cnt) > MAX_SEGMENTS) begin
            u_cnt = CNT_W'(MAX_SEGMENTS);
        end
        if (int'(v_cnt) > MAX_SEGMENTS) begin
            v_cnt = CNT_W'(MAX_SEGMENTS);
        end
        span_ok = (MAX_SEGMENTS > (1 << SPAN_OUT_W))
                  || ((CNT_W'(o_u_span) < u_cnt) && (CNT_W'(o_v_span) < v_cnt));
    end

    `BPSE_ASSERT_IMP(a_result_has_eval, i_clk, i_rst_n, o_valid, $past(eval_acc, PIPE_LAT), "result strobe without an evaluation accepted at the pipe latency")
    `BPSE_ASSERT_DLY(a_eval_gives_result, i_clk, i_rst_n, eval_acc, PIPE_LAT, o_valid, "accepted evaluation gave no result")
    `BPSE_ASSERT_IMP(a_span_in_range, i_clk, i_rst_n, o_valid, span_ok, "span outside the segments in use")

endmodule

bind bicubic_power_surface_eval bpse_chk #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_bpse_chk (.*);
